[rtl/lpo_pkg.sv]
// Package with shared types and widths for the log position mapper.
package lpo_pkg;

	localparam int POS_W  = 63;
	localparam int SIZE_W = 41;
	localparam int CNT_W  = 7;
	localparam int TOT_W  = 48;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_FILE_SIZE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FILE_COUNT = 2'd1;

	typedef struct packed {
		logic [TOT_W-1:0] r;
		logic [POS_W-1:0] d;
		logic             neg;
	} mod_t;

	typedef struct packed {
		logic [TOT_W-1:0] rem;
		logic [CNT_W-1:0] q;
	} div_t;

endpackage

[rtl/lpo_ifs.sv]
// Stream and configuration channel interfaces of the log position mapper.
interface lpo_in_if;
	logic                      valid;
	logic                      ready;
	logic [lpo_pkg::POS_W-1:0] position;
	logic [lpo_pkg::POS_W-1:0] reference_position;
	modport source (output valid, position, reference_position, input ready);
	modport sink (input valid, position, reference_position, output ready);
endinterface

interface lpo_out_if;
	logic                       valid;
	logic                       ready;
	logic [lpo_pkg::CNT_W-1:0]  file_index;
	logic [lpo_pkg::SIZE_W-1:0] byte_offset;
	modport source (output valid, file_index, byte_offset, input ready);
	modport sink (input valid, file_index, byte_offset, output ready);
endinterface

interface lpo_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lpo_pkg::IDX_W-1:0]  index;
	logic [lpo_pkg::SIZE_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/lpo_mod_stage.sv]
// One restoring step of the distance modulo the ring size.
module lpo_mod_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_i,
	input  lpo_pkg::mod_t             x_i,
	input  logic [lpo_pkg::TOT_W-1:0] total,
	output logic                      v_o,
	output lpo_pkg::mod_t             x_o
);
	logic [lpo_pkg::TOT_W:0] t;
	lpo_pkg::mod_t           nx;

	always_comb begin
		t = {x_i.r, x_i.d[lpo_pkg::POS_W-1]};
		if (t >= {1'b0, total}) begin
			t = t - {1'b0, total};
		end
		nx.r   = t[lpo_pkg::TOT_W-1:0];
		nx.d   = {x_i.d[lpo_pkg::POS_W-2:0], 1'b0};
		nx.neg = x_i.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= nx;
		end
	end
endmodule

[rtl/lpo_div_stage.sv]
// One quotient bit of the ring distance divided by the file capacity.
module lpo_div_stage #(
	parameter int SHIFT = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_i,
	input  lpo_pkg::div_t              x_i,
	input  logic [lpo_pkg::SIZE_W-1:0] cap,
	output logic                       v_o,
	output lpo_pkg::div_t              x_o
);
	logic [lpo_pkg::TOT_W-1:0] capk;
	lpo_pkg::div_t             nx;

	always_comb begin
		capk = {{(lpo_pkg::TOT_W-lpo_pkg::SIZE_W){1'b0}}, cap} << SHIFT;
		nx   = x_i;
		if (x_i.rem >= capk) begin
			nx.rem      = x_i.rem - capk;
			nx.q[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= nx;
		end
	end
endmodule

[rtl/log_position_to_file_offset.sv]
// Top level of the log position to file offset mapper.
// Maps a log sequence number onto a ring of equal log files.
// Input channel: position and reference_position, one beat per cycle.
// Output channel: file_index and byte_offset, one beat per input beat,
// in order. Configuration channel: index 0 writes file_size_bytes,
// index 1 writes file_count; other indexes are ignored. Write only while
// no beat is in flight.
// The pipeline has one input stage, 63 stages of the restoring modulo
// (one dividend bit each), one wrap fixup stage, seven quotient stages
// and the output register.
// Throughput is one beat per cycle. The whole pipeline advances
// together; when the receiver stalls a full output register, every
// stage holds and input ready drops, so nothing is lost or repeated.
// Reset empties the pipeline and restores a 5242880 byte file size and
// a file count of two.
module log_position_to_file_offset #(
	parameter int HEADER_BYTES = 2048
) (
	input  logic  clk,
	input  logic  arst_n,
	lpo_in_if.sink    in_ch,
	lpo_out_if.source out_ch,
	lpo_cfg_if.sink   cfg
);
	localparam int MS = lpo_pkg::POS_W;
	localparam int DS = lpo_pkg::CNT_W;
	localparam logic [lpo_pkg::SIZE_W-1:0] HDR = lpo_pkg::SIZE_W'(HEADER_BYTES);

	logic [lpo_pkg::SIZE_W-1:0] cap_q;
	logic [lpo_pkg::TOT_W-1:0]  total_q;
	logic [lpo_pkg::SIZE_W-1:0] size_q;
	logic [lpo_pkg::CNT_W-1:0]  count_q;
	logic                       degen_q;
	logic [lpo_pkg::SIZE_W-1:0] new_size;
	logic [lpo_pkg::CNT_W-1:0]  new_count;
	logic [lpo_pkg::SIZE_W-1:0] new_cap;
	logic                       adv;

	assign cfg.ready = 1'b1;
	assign adv       = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	always_comb begin
		new_size  = size_q;
		new_count = count_q;
		if (cfg.index == lpo_pkg::REG_FILE_SIZE) begin
			new_size = cfg.data;
		end else if (cfg.index == lpo_pkg::REG_FILE_COUNT) begin
			new_count = cfg.data[lpo_pkg::CNT_W-1:0];
		end
		new_cap = new_size - HDR;
	end

	// Capacity and ring size are derived at write time to keep the multiply off the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= lpo_pkg::SIZE_W'(5242880);
			count_q <= lpo_pkg::CNT_W'(2);
			cap_q   <= lpo_pkg::SIZE_W'(5242880) - HDR;
			total_q <= lpo_pkg::TOT_W'((5242880 - HEADER_BYTES) * 2);
			degen_q <= (5242880 <= HEADER_BYTES);
		end else if (cfg.valid) begin
			size_q  <= new_size;
			count_q <= new_count;
			cap_q   <= new_cap;
			total_q <= lpo_pkg::TOT_W'(new_cap) * lpo_pkg::TOT_W'(new_count);
			degen_q <= (new_size <= HDR) || (new_count == '0);
		end
	end

	logic          mv [0:MS];
	lpo_pkg::mod_t mx [0:MS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv[0] <= 1'b0;
		end else if (adv) begin
			mv[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx[0].r <= '0;
			if (in_ch.position >= in_ch.reference_position) begin
				mx[0].d   <= in_ch.position - in_ch.reference_position;
				mx[0].neg <= 1'b0;
			end else begin
				mx[0].d   <= in_ch.reference_position - in_ch.position;
				mx[0].neg <= 1'b1;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MS; gi++) begin : g_mod
			lpo_mod_stage u_mod (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.v_i(mv[gi]), .x_i(mx[gi]), .total(total_q),
				.v_o(mv[gi+1]), .x_o(mx[gi+1])
			);
		end
	endgenerate

	logic          dv [0:DS];
	lpo_pkg::div_t dx [0:DS];

	// A position before the reference wraps forward to the ring complement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (adv) begin
			dv[0] <= mv[MS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx[0].q <= '0;
			if (mx[MS].neg && (mx[MS].r != '0)) begin
				dx[0].rem <= total_q - mx[MS].r;
			end else begin
				dx[0].rem <= mx[MS].r;
			end
		end
	end

	generate
		for (gi = 0; gi < DS; gi++) begin : g_div
			lpo_div_stage #(.SHIFT(DS - 1 - gi)) u_div (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.v_i(dv[gi]), .x_i(dx[gi]), .cap(cap_q),
				.v_o(dv[gi+1]), .x_o(dx[gi+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= dv[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (degen_q) begin
				out_ch.file_index  <= '0;
				out_ch.byte_offset <= HDR;
			end else begin
				out_ch.file_index  <= dx[DS].q;
				out_ch.byte_offset <= dx[DS].rem[lpo_pkg::SIZE_W-1:0] + HDR;
			end
		end
	end
endmodule

[test/log_position_to_file_offset_test.sv]
// Testbench for the log position to file offset mapper.
module log_position_to_file_offset_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR = 2048;
	localparam longint LIMIT = 2000000;
	localparam int PW = lpo_pkg::POS_W;
	localparam int SW = lpo_pkg::SIZE_W;
	localparam int CW = lpo_pkg::CNT_W;

	typedef struct packed {
		logic [CW-1:0] file_index;
		logic [SW-1:0] byte_offset;
	} location_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	lpo_in_if in_ch();
	lpo_out_if out_ch();
	lpo_cfg_if cfg();

	log_position_to_file_offset i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [SW-1:0] cur_file_size = 41'd5242880;
	logic [CW-1:0] cur_file_count = 7'd2;
	location_t expected_locations[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.position = '0;
		in_ch.reference_position = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	function automatic location_t locate(logic [PW-1:0] pos, logic [PW-1:0] refp);
		location_t loc;
		logic [63:0] capacity;
		logic [63:0] ring;
		logic [63:0] distance;
		loc.file_index = '0;
		loc.byte_offset = SW'(HDR);
		if (cur_file_size <= HDR || cur_file_count == 0)
			return loc;
		capacity = 64'(cur_file_size) - HDR;
		ring = capacity * 64'(cur_file_count);
		if (pos >= refp)
			distance = 64'(pos - refp) % ring;
		else
			distance = (ring - (64'(refp - pos) % ring)) % ring;
		loc.file_index = CW'(distance / capacity);
		loc.byte_offset = SW'((distance % capacity) + HDR);
		return loc;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Result checker and receiver stall generation.
	always @(posedge clk) begin
		location_t want;
		cycles <= cycles + 1;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_locations.size() == 0) begin
				$display("mismatch: unexpected result beat");
				errors++;
			end else begin
				want = expected_locations.pop_front();
				if (out_ch.file_index !== want.file_index)
					report("file_index", 64'(out_ch.file_index), 64'(want.file_index));
				if (out_ch.byte_offset !== want.byte_offset)
					report("byte_offset", 64'(out_ch.byte_offset), 64'(want.byte_offset));
			end
			checked++;
		end
		if (arst_n)
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk)
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("simulation failed");
			$finish;
		end

	// Valid stays high between back to back beats; idling and draining lower it.
	task automatic send_location(logic [PW-1:0] pos, logic [PW-1:0] refp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.position <= pos;
		in_ch.reference_position <= refp;
		expected_locations.push_back(locate(pos, refp));
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_locations.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_register(logic [lpo_pkg::IDX_W-1:0] idx, logic [SW-1:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == lpo_pkg::REG_FILE_SIZE)
			cur_file_size = value;
		else if (idx == lpo_pkg::REG_FILE_COUNT)
			cur_file_count = CW'(value);
	endtask

	function automatic logic [PW-1:0] rand_pos();
		return PW'({$urandom(), $urandom()});
	endfunction

	task automatic test_directed();
		logic [PW-1:0] top;
		top = {PW{1'b1}};
		send_location(PW'(0), PW'(0));
		send_location(top, top);
		send_location(top, PW'(0));
		send_location(PW'(0), top);
		send_location(PW'(1), PW'(0));
		send_location(PW'(0), PW'(1));
		send_location(PW'(64'd5238784 * 2), PW'(0));
		send_location(PW'(64'd5238784 * 2 - 1), PW'(0));
		send_location(PW'(64'd5238784), PW'(0));
		send_location(PW'(64'd5238783), PW'(0));
		send_location(PW'(100), PW'(100 + 64'd5238784 * 2));
		send_location(rand_pos(), rand_pos());
	endtask

	task automatic test_registers();
		write_register(lpo_pkg::REG_FILE_SIZE, 41'd2048);
		send_location(PW'(12345), PW'(17));
		write_register(lpo_pkg::REG_FILE_SIZE, 41'd1000);
		send_location(PW'(17), PW'(12345));
		write_register(lpo_pkg::REG_FILE_SIZE, 41'd4096);
		write_register(lpo_pkg::REG_FILE_COUNT, 41'd0);
		send_location(PW'(99), PW'(3));
		write_register(lpo_pkg::REG_FILE_COUNT, 41'd1);
		send_location(PW'(5000), PW'(1));
		send_location(PW'(1), PW'(5000));
		// Writes to an unused index must leave the settings untouched.
		write_register(2'd2, 41'd7777);
		write_register(2'd3, 41'h1FFFFFFFFFF);
		send_location(rand_pos(), rand_pos());
		write_register(lpo_pkg::REG_FILE_SIZE, 41'h1FFFFFFFFFF);
		write_register(lpo_pkg::REG_FILE_COUNT, 41'h7F);
		send_location({PW{1'b1}}, PW'(0));
		send_location(PW'(0), {PW{1'b1}});
		write_register(lpo_pkg::REG_FILE_SIZE, 41'd1 << 40);
		write_register(lpo_pkg::REG_FILE_COUNT, 41'd100);
		send_location({PW{1'b1}}, PW'(3));
		send_location(PW'(3), {PW{1'b1}});
	endtask

	task automatic test_random(int count);
		logic [PW-1:0] a;
		logic [PW-1:0] b;
		logic [63:0] ring;
		for (int i = 0; i < count; i++) begin
			ring = (64'(cur_file_size) - HDR) * 64'(cur_file_count);
			a = rand_pos();
			case ($urandom_range(3))
				0: b = rand_pos();
				1: b = a + PW'($urandom_range(3) * ring) - PW'($urandom_range(2));
				2: b = a - PW'({$urandom(), $urandom()} % (ring * 3 + 1));
				default: b = PW'($urandom_range(1)) ? {PW{1'b1}} : '0;
			endcase
			if ($urandom_range(1)) send_location(a, b);
			else send_location(b, a);
		end
	endtask

	task automatic random_settings();
		case ($urandom_range(3))
			0: write_register(lpo_pkg::REG_FILE_SIZE, SW'($urandom_range(4096, 9000)));
			1: write_register(lpo_pkg::REG_FILE_SIZE, SW'({$urandom(), $urandom()}) | 41'd4096);
			2: write_register(lpo_pkg::REG_FILE_SIZE, 41'd5242880);
			default: write_register(lpo_pkg::REG_FILE_SIZE, SW'({$urandom(), $urandom()}));
		endcase
		write_register(lpo_pkg::REG_FILE_COUNT, SW'($urandom_range(100)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 65; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 65; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			random_settings();
			test_random(95);
		end
		write_register(lpo_pkg::REG_FILE_SIZE, 41'd4096);
		write_register(lpo_pkg::REG_FILE_COUNT, 41'd1);
		test_random(20);
		drain();
		$display("sent %0d positions, checked %0d locations over many ring sizes", sent, checked);
		$display("including wrapped, aligned and degenerate configurations");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
